/* rtl/kds_pkg.sv */
// Package for the keyword detection smoother: field widths, register
// indexes and stream packing constants.
// No dependencies.
`timescale 1ns / 1ps

package kds_pkg;

    // Number of classifier classes; a class index at or above it is rejected
    localparam int NUM_CLASSES   = 16;
    localparam int CLASS_CMP_W   = 9;   // wide enough to hold NUM_CLASSES up to 256

    localparam int CLASS_W       = 4;
    localparam int PROB_W        = 16;
    localparam int COUNT_W       = 9;   // signed run count, -255..255
    localparam int RUN_W         = 8;

    // Stream payload packing, padded to whole bytes
    localparam int S_TDATA_W     = 24;  // [3:0] class_index, [19:4] probability
    localparam int M_TDATA_W     = 24;  // [3:0] detected_class, [19:4] smoothed_probability
    localparam int M_TUSER_W     = 1;   // [0] detected

    // Configuration port
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EMA_WEIGHT       = 3'd0,
        REG_DETECT_THRESHOLD = 3'd1,
        REG_RUN_LENGTH       = 3'd2,
        REG_HOLDOFF_FRAMES   = 3'd3,
        REG_REJECT_CLASS_A   = 3'd4,
        REG_REJECT_CLASS_B   = 3'd5
    } cfg_reg_t;

    // Register reset values
    localparam logic [PROB_W-1:0]  EMA_WEIGHT_RST       = 16'd32768;
    localparam logic [PROB_W-1:0]  DETECT_THRESHOLD_RST = 16'd52429;
    localparam logic [RUN_W-1:0]   RUN_LENGTH_RST       = 8'd10;
    localparam logic [RUN_W-1:0]   HOLDOFF_FRAMES_RST   = 8'd10;
    localparam logic [CLASS_W-1:0] REJECT_CLASS_A_RST   = 4'd0;
    localparam logic [CLASS_W-1:0] REJECT_CLASS_B_RST   = 4'd1;

    // One frame verdict after unpacking
    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [PROB_W-1:0]  probability;
    } frame_t;

endpackage

/* rtl/keyword_detection_smoother.sv */
// Keyword detection smoother top level: run counting, moving average and
// detection of classifier verdicts, one frame per transfer.
// Depends on kds_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: class_index, probability
// m_        out        m_tvalid/m_tready  m_tdata: detected_class, smoothed_probability;
//                                         m_tuser: detected
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each frame passes the input register, then the average multiply-add into
// the result register. A new frame is accepted in every cycle unless a stall
// on m_ has filled both registers; the single 17x17 multiply of the average
// update sets the path length. aresetn (synchronous, active low) restores
// register defaults and clears run count, average and previous class.
// A stall on m_ holds the result; the input register holds one more frame.
// Configuration writes are always accepted and take effect next cycle.

module keyword_detection_smoother (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kds_pkg::S_TDATA_W-1:0]     s_tdata,   // [3:0] class_index, [19:4] probability

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kds_pkg::M_TDATA_W-1:0]     m_tdata,   // [3:0] detected_class,
                                                         // [19:4] smoothed_probability
    output logic [kds_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] detected

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kds_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kds_pkg::*;

    // Configuration registers
    logic [PROB_W-1:0]  ema_weight_reg;
    logic [PROB_W-1:0]  detect_threshold_reg;
    logic [RUN_W-1:0]   run_length_reg;
    logic [RUN_W-1:0]   holdoff_frames_reg;
    logic [CLASS_W-1:0] reject_class_a_reg;
    logic [CLASS_W-1:0] reject_class_b_reg;

    // Smoother state
    logic [CLASS_W-1:0]        previous_class_reg, previous_class_next;
    logic signed [COUNT_W-1:0] run_count_reg, run_count_next;
    logic [PROB_W-1:0]         average_reg, average_next;

    // Input register
    logic   in_vld_reg;
    frame_t in_frame_reg;

    // Result register
    logic               out_vld_reg;
    logic               out_det_reg, out_det_next;
    logic [CLASS_W-1:0] out_class_reg, out_class_next;
    logic [PROB_W-1:0]  out_prob_reg, out_prob_next;

    logic out_ready;   // result register can take a new result this cycle
    logic out_load;    // the held frame moves into the result register

    // Advance the result register when empty or being drained
    assign out_ready = !out_vld_reg || m_tready;
    assign out_load  = in_vld_reg && out_ready;
    assign s_tready  = !in_vld_reg || out_ready;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Frame evaluation
    // ---------------------------------------------------------------
    logic                       is_reject;
    logic                       class_change;
    logic signed [COUNT_W-1:0]  run_base;
    logic signed [COUNT_W-1:0]  run_len_s;
    logic signed [COUNT_W-1:0]  run_inc;
    logic [PROB_W-1:0]          avg_base;
    logic signed [PROB_W:0]     prob_diff;
    logic signed [PROB_W:0]     weight_s;
    logic signed [2*PROB_W+1:0] ema_prod;
    logic signed [PROB_W+1:0]   ema_delta;
    logic signed [PROB_W+1:0]   avg_sum;
    logic [PROB_W-1:0]          avg_new;
    logic                       fire;

    always_comb begin
        // Reject on either reject class or on a class outside the table
        is_reject = (in_frame_reg.class_index == reject_class_a_reg)
                 || (in_frame_reg.class_index == reject_class_b_reg)
                 || ({{(CLASS_CMP_W-CLASS_W){1'b0}}, in_frame_reg.class_index}
                     >= CLASS_CMP_W'(NUM_CLASSES));

        // A new keyword class restarts the run and the average
        class_change = (in_frame_reg.class_index != previous_class_reg);
        run_base     = class_change ? '0 : run_count_reg;
        avg_base     = class_change ? '0 : average_reg;

        // Count the frame, saturating at the run length
        run_len_s = $signed({1'b0, run_length_reg});
        run_inc   = (run_base < run_len_s) ? run_base + COUNT_W'(1) : run_len_s;

        // avg + w*(p - avg)/65536, floored; equals the two-product form exactly
        prob_diff = $signed({1'b0, in_frame_reg.probability}) - $signed({1'b0, avg_base});
        weight_s  = $signed({1'b0, ema_weight_reg});
        ema_prod  = prob_diff * weight_s;
        ema_delta = ema_prod[2*PROB_W+1:PROB_W];
        avg_sum   = $signed({2'b00, avg_base}) + ema_delta;
        avg_new   = avg_sum[PROB_W-1:0];

        fire = (run_inc >= run_len_s) && (avg_new >= detect_threshold_reg);

        // Defaults: hold state, empty result
        previous_class_next = previous_class_reg;
        run_count_next      = run_count_reg;
        average_next        = average_reg;
        out_det_next        = 1'b0;
        out_class_next      = '0;
        out_prob_next       = '0;

        if (is_reject) begin
            run_count_next = '0;
            average_next   = '0;
        end else begin
            previous_class_next = in_frame_reg.class_index;
            if (fire) begin
                // Report, then start the hold-off with a negative count
                out_det_next   = 1'b1;
                out_class_next = in_frame_reg.class_index;
                out_prob_next  = avg_new;
                run_count_next = -$signed({1'b0, holdoff_frames_reg});
                average_next   = '0;
            end else begin
                run_count_next = run_inc;
                average_next   = avg_new;
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_weight_reg       <= EMA_WEIGHT_RST;
            detect_threshold_reg <= DETECT_THRESHOLD_RST;
            run_length_reg       <= RUN_LENGTH_RST;
            holdoff_frames_reg   <= HOLDOFF_FRAMES_RST;
            reject_class_a_reg   <= REJECT_CLASS_A_RST;
            reject_class_b_reg   <= REJECT_CLASS_B_RST;
            previous_class_reg   <= '0;
            run_count_reg        <= '0;
            average_reg          <= '0;
            in_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
        end else begin
            // Configuration write; indexes beyond the list are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EMA_WEIGHT:       ema_weight_reg       <= cfg_data;
                    REG_DETECT_THRESHOLD: detect_threshold_reg <= cfg_data;
                    REG_RUN_LENGTH:       run_length_reg       <= cfg_data[RUN_W-1:0];
                    REG_HOLDOFF_FRAMES:   holdoff_frames_reg   <= cfg_data[RUN_W-1:0];
                    REG_REJECT_CLASS_A:   reject_class_a_reg   <= cfg_data[CLASS_W-1:0];
                    REG_REJECT_CLASS_B:   reject_class_b_reg   <= cfg_data[CLASS_W-1:0];
                    default: ;
                endcase
            end

            // Input register fills on a transfer, empties as it moves on
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (out_load) begin
                in_vld_reg <= 1'b0;
            end

            // Commit state and the result together
            if (out_load) begin
                previous_class_reg <= previous_class_next;
                run_count_reg      <= run_count_next;
                average_reg        <= average_next;
                out_vld_reg        <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_frame_reg.class_index <= s_tdata[CLASS_W-1:0];
            in_frame_reg.probability <= s_tdata[CLASS_W+PROB_W-1:CLASS_W];
        end
        if (out_load) begin
            out_det_reg   <= out_det_next;
            out_class_reg <= out_class_next;
            out_prob_reg  <= out_prob_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-CLASS_W-PROB_W){1'b0}}, out_prob_reg, out_class_reg};
    assign m_tuser  = out_det_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A result without a detection carries all-zero data
    a_quiet_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("non-detection result carries nonzero data");

    // A detection clears the average and leaves a non-positive count
    a_detect_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_det_next) |=> (average_reg == '0) && (run_count_reg <= 0))
        else $error("state not cleared after detection");

    // A committed frame always shows up as a pending result
    a_load_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_vld_reg)
        else $error("result lost after commit");

endmodule
